// File: rtl/tpac_pkg.sv
// ----------------------------------------------------------------------------
// tpac_pkg
// Shared types and constants for the triac phase-angle controller.
// ----------------------------------------------------------------------------
package tpac_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int DELAY_W  = 14;
    localparam int PULSE_W  = 8;
    localparam int MODE_W   = 2;

    // ADC full scale and its shift; the scaling divide is a right shift
    localparam int ADC_FULL_SCALE = 4096;
    localparam int ADC_FS_LOG2    = $clog2(ADC_FULL_SCALE);
    localparam int CLAMP_W        = ADC_FS_LOG2 + 1;
    localparam int PROD_W         = CLAMP_W + DELAY_W;
    localparam int QUOT_W         = PROD_W - ADC_FS_LOG2;

    // Event codes
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ZC     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd2;

    // APB map
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_DEADBAND  = 2'd0;
    localparam logic [1:0] REG_MAX_DELAY = 2'd1;
    localparam logic [1:0] REG_MIN_DELAY = 2'd2;
    localparam logic [1:0] REG_PULSE     = 2'd3;

    // Reset values
    localparam logic [SAMPLE_W-1:0] DEADBAND_RST  = 12'd50;
    localparam logic [DELAY_W-1:0]  MAX_DELAY_RST = 14'd8333;
    localparam logic [DELAY_W-1:0]  MIN_DELAY_RST = 14'd500;
    localparam logic [PULSE_W-1:0]  PULSE_RST     = 8'd1;
    localparam logic [DELAY_W-1:0]  DELAY_VAL_RST = MAX_DELAY_RST - 14'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] deadband_margin;
        logic [DELAY_W-1:0]  max_delay_ticks;
        logic [DELAY_W-1:0]  min_delay_ticks;
        logic [PULSE_W-1:0]  pulse_ticks;
    } cfg_t;

endpackage

// File: rtl/tpac_regs.sv
// ----------------------------------------------------------------------------
// tpac_regs
// APB register bank: deadband, max/min delay and pulse width.
// ----------------------------------------------------------------------------
module tpac_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tpac_pkg::APB_AW-1:0]      paddr,
    input  logic [tpac_pkg::APB_DW-1:0]      pwdata,
    output logic [tpac_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    output tpac_pkg::cfg_t                   cfg
);

    tpac_pkg::cfg_t cfg_reg;
    tpac_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                tpac_pkg::REG_DEADBAND:
                    cfg_next.deadband_margin = pwdata[tpac_pkg::SAMPLE_W-1:0];
                tpac_pkg::REG_MAX_DELAY:
                    cfg_next.max_delay_ticks = pwdata[tpac_pkg::DELAY_W-1:0];
                tpac_pkg::REG_MIN_DELAY:
                    cfg_next.min_delay_ticks = pwdata[tpac_pkg::DELAY_W-1:0];
                tpac_pkg::REG_PULSE:
                    cfg_next.pulse_ticks = pwdata[tpac_pkg::PULSE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband_margin <= tpac_pkg::DEADBAND_RST;
            cfg_reg.max_delay_ticks <= tpac_pkg::MAX_DELAY_RST;
            cfg_reg.min_delay_ticks <= tpac_pkg::MIN_DELAY_RST;
            cfg_reg.pulse_ticks     <= tpac_pkg::PULSE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            tpac_pkg::REG_DEADBAND:
                prdata = {{(tpac_pkg::APB_DW-tpac_pkg::SAMPLE_W){1'b0}},
                          cfg_reg.deadband_margin};
            tpac_pkg::REG_MAX_DELAY:
                prdata = {{(tpac_pkg::APB_DW-tpac_pkg::DELAY_W){1'b0}},
                          cfg_reg.max_delay_ticks};
            tpac_pkg::REG_MIN_DELAY:
                prdata = {{(tpac_pkg::APB_DW-tpac_pkg::DELAY_W){1'b0}},
                          cfg_reg.min_delay_ticks};
            tpac_pkg::REG_PULSE:
                prdata = {{(tpac_pkg::APB_DW-tpac_pkg::PULSE_W){1'b0}},
                          cfg_reg.pulse_ticks};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/tpac_scale.sv
// ----------------------------------------------------------------------------
// tpac_scale
// Sample to delay: clamp, multiply by max delay, shift down, floor at min.
// ----------------------------------------------------------------------------
module tpac_scale
(
    input  logic [tpac_pkg::SAMPLE_W-1:0] sample,
    input  tpac_pkg::cfg_t                cfg,
    output logic [tpac_pkg::DELAY_W-1:0]  scaled
);

    logic [tpac_pkg::CLAMP_W-1:0] clamped;
    logic [tpac_pkg::PROD_W-1:0]  prod;
    logic [tpac_pkg::QUOT_W-1:0]  quot;
    logic [tpac_pkg::QUOT_W-1:0]  min_ext;

    always_comb
    begin
        clamped = tpac_pkg::CLAMP_W'(sample);
        if (clamped > tpac_pkg::CLAMP_W'(tpac_pkg::ADC_FULL_SCALE))
            clamped = tpac_pkg::CLAMP_W'(tpac_pkg::ADC_FULL_SCALE);
    end

    assign prod    = tpac_pkg::PROD_W'(clamped) * tpac_pkg::PROD_W'(cfg.max_delay_ticks);
    assign quot    = prod[tpac_pkg::PROD_W-1:tpac_pkg::ADC_FS_LOG2];
    assign min_ext = tpac_pkg::QUOT_W'(cfg.min_delay_ticks);
    assign scaled  = (quot < min_ext) ? cfg.min_delay_ticks
                                      : quot[tpac_pkg::DELAY_W-1:0];

endmodule

// File: rtl/tpac_core.sv
// ----------------------------------------------------------------------------
// tpac_core
// Input register, controller state update and result register.
// ----------------------------------------------------------------------------
module tpac_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tpac_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tpac_pkg::MODE_W-1:0]   mode,
    input  logic [tpac_pkg::SAMPLE_W-1:0] adc_sample,
    input  logic [tpac_pkg::DELAY_W-1:0]  scaled,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          gate_on,
    output logic                          fired,
    output logic [tpac_pkg::DELAY_W-1:0]  delay_now,
    output logic                          sample_taken
);

    // input stage
    logic                          in_vld_reg;
    logic [tpac_pkg::MODE_W-1:0]   in_mode_reg;
    logic [tpac_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic [tpac_pkg::DELAY_W-1:0]  in_scaled_reg;

    // controller state
    logic [tpac_pkg::SAMPLE_W-1:0] last_reg, last_next;
    logic [tpac_pkg::DELAY_W-1:0]  delay_reg, delay_next;
    logic [tpac_pkg::DELAY_W-1:0]  count_reg, count_next;
    logic                          counting_reg, counting_next;
    logic [tpac_pkg::PULSE_W-1:0]  pulse_reg, pulse_next;

    // result stage
    logic                          out_vld_reg;
    logic                          gate_reg;
    logic                          fired_reg, fired_next;
    logic                          taken_reg, taken_next;

    logic                          advance;
    logic                          accept;
    logic                          fire;
    logic [tpac_pkg::DELAY_W-1:0]  count_inc;
    logic [tpac_pkg::SAMPLE_W-1:0] diff;
    logic [tpac_pkg::PULSE_W-1:0]  pulse_load;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign accept   = in_valid && in_ready;

    assign count_inc  = count_reg + 1'b1;
    assign diff       = (last_reg > in_sample_reg) ? last_reg - in_sample_reg
                                                   : in_sample_reg - last_reg;
    assign pulse_load = (cfg.pulse_ticks == '0) ? tpac_pkg::PULSE_W'(1)
                                                : cfg.pulse_ticks;

    always_comb
    begin
        last_next     = last_reg;
        delay_next    = delay_reg;
        count_next    = count_reg;
        counting_next = counting_reg;
        pulse_next    = pulse_reg;
        fire          = 1'b0;
        taken_next    = 1'b0;
        case (in_mode_reg)
            tpac_pkg::MODE_TICK:
            begin
                if (pulse_reg != '0)
                    pulse_next = pulse_reg - 1'b1;
                if (counting_reg)
                begin
                    count_next = count_inc;
                    if (count_inc >= delay_reg)
                        fire = 1'b1;
                end
            end
            tpac_pkg::MODE_ZC:
            begin
                if (!counting_reg)
                begin
                    counting_next = 1'b1;
                    count_next    = '0;
                end
            end
            tpac_pkg::MODE_SAMPLE:
            begin
                if (diff >= cfg.deadband_margin)
                begin
                    taken_next = 1'b1;
                    last_next  = in_sample_reg;
                    delay_next = in_scaled_reg;
                    if (counting_reg && (count_reg >= in_scaled_reg))
                        fire = 1'b1;
                end
            end
            default:
            begin
                fire = 1'b0;
            end
        endcase
        if (fire)
        begin
            counting_next = 1'b0;
            count_next    = '0;
            pulse_next    = pulse_load;
        end
        fired_next = fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            last_reg     <= '0;
            delay_reg    <= tpac_pkg::DELAY_VAL_RST;
            count_reg    <= '0;
            counting_reg <= 1'b0;
            pulse_reg    <= '0;
        end
        else
        begin
            if (accept)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;

            if (advance)
            begin
                last_reg     <= last_next;
                delay_reg    <= delay_next;
                count_reg    <= count_next;
                counting_reg <= counting_next;
                pulse_reg    <= pulse_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_mode_reg   <= mode;
            in_sample_reg <= adc_sample;
            in_scaled_reg <= scaled;
        end
        if (advance)
        begin
            gate_reg  <= (pulse_next != '0);
            fired_reg <= fired_next;
            taken_reg <= taken_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign gate_on      = gate_reg;
    assign fired        = fired_reg;
    assign delay_now    = delay_reg;
    assign sample_taken = taken_reg;

endmodule

// File: rtl/triac_phase_angle_controller.sv
// ----------------------------------------------------------------------------
// triac_phase_angle_controller
// Phase-angle triac dimmer: tick, zero-crossing and ADC sample events in,
// one status item out per event.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event per item: mode 0 is
//   a 1 us tick, mode 1 a mains zero crossing, mode 2 a new ADC sample in
//   adc_sample. Every item yields exactly one result item on the output
//   channel (out_valid/out_ready): gate_on, fired, delay_now, sample_taken.
//   Each item passes from the input register to the result register.
//   Throughput: one item per cycle while the receiver keeps out_ready high,
//   set by the single state-update stage between the input register and the result register.
//   The sample scaling multiply (13 x 14 bits) sits in front of the input
//   register, so the state stage only compares and counts.
//   When the receiver stalls, the result register holds; the input register
//   still takes one further item, after which in_ready drops until the
//   result is taken.
//   Reset (rst_n low, asynchronous) empties both stages, loads the default
//   register values (deadband 50, max delay 8333, min delay 500, pulse 1)
//   and sets the firing delay to 8332 with the counter idle.
//   The user writes APB registers only while no item is in flight; unchecked.
// ----------------------------------------------------------------------------
module triac_phase_angle_controller
(
    input  logic                             clk,
    input  logic                             rst_n,
    // APB configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tpac_pkg::APB_AW-1:0]      paddr,
    input  logic [tpac_pkg::APB_DW-1:0]      pwdata,
    output logic [tpac_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    // event input
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tpac_pkg::MODE_W-1:0]      mode,
    input  logic [tpac_pkg::SAMPLE_W-1:0]    adc_sample,
    // status output
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             gate_on,
    output logic                             fired,
    output logic [tpac_pkg::DELAY_W-1:0]     delay_now,
    output logic                             sample_taken
);

    tpac_pkg::cfg_t                 cfg;
    logic [tpac_pkg::DELAY_W-1:0]   scaled;

    tpac_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // scale every incoming sample; only used by sample events
    tpac_scale u_scale
    (
        .sample (adc_sample),
        .cfg    (cfg),
        .scaled (scaled)
    );

    tpac_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .adc_sample   (adc_sample),
        .scaled       (scaled),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .gate_on      (gate_on),
        .fired        (fired),
        .delay_now    (delay_now),
        .sample_taken (sample_taken)
    );

endmodule

// File: rtl/tpac_checker.sv
// ----------------------------------------------------------------------------
// tpac_checker
// Port-level checks for the triac phase-angle controller.
// ----------------------------------------------------------------------------
module tpac_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         gate_on,
    input  logic                         fired,
    input  logic [tpac_pkg::DELAY_W-1:0] delay_now,
    input  logic                         sample_taken
);

    logic [tpac_pkg::DELAY_W-1:0] prev_delay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_delay_reg <= tpac_pkg::DELAY_VAL_RST;
        else if (out_valid && out_ready)
            prev_delay_reg <= delay_now;
    end

    // a firing item always shows the gate driven
    a_fire_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> gate_on)
        else $error("fired without gate_on");

    // the delay only moves on an item whose sample was taken
    a_delay_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sample_taken |-> delay_now == prev_delay_reg)
        else $error("delay changed without a taken sample");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gate_on) && $stable(fired)
            && $stable(delay_now) && $stable(sample_taken))
        else $error("stalled result changed");

endmodule

bind triac_phase_angle_controller tpac_checker u_tpac_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .gate_on      (gate_on),
    .fired        (fired),
    .delay_now    (delay_now),
    .sample_taken (sample_taken)
);
